@@ rtl/tagged_pointer_object_table_core_defines.svh @@
// ----------------------------------------------------------------------------
// Tagged pointer object table: assertion macros
// Shared assertion forms, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TAGGED_POINTER_OBJECT_TABLE_CORE_DEFINES_SVH
`define TAGGED_POINTER_OBJECT_TABLE_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define TPOT_ASSERT_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define TPOT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TPOT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tpot_pkg.sv @@
// ----------------------------------------------------------------------------
// Tagged pointer object table package
// Field widths, operation and status codes, beat and table entry types.
// ----------------------------------------------------------------------------
`default_nettype none

package tpot_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 512;

  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned PTR_W     = 64;
  localparam int unsigned TAG_W     = PTR_W - ADDR_W;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REALLOC = 2'd2,
    OP_CHECK   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_UNTAGGED   = 3'd1,
    ST_BAD_TAG    = 3'd2,
    ST_NOT_IN_USE = 3'd3,
    ST_FULL       = 3'd4,
    ST_UNTRACKED  = 3'd5
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [PTR_W-1:0]  tagged_pointer;
    logic [ADDR_W-1:0] block_address;
    logic [ADDR_W-1:0] block_size;
  } in_item_t;

  typedef struct packed {
    logic [PTR_W-1:0] result_pointer;
    status_t          status;
    logic             in_bounds;
    logic             base_mismatch;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
    logic              in_use;
  } entry_t;

  // free list commands from the op logic
  typedef struct packed {
    logic pop;
    logic push;
  } stk_cmd_t;

endpackage

`default_nettype wire

@@ rtl/tpot_entry_mem.sv @@
// ----------------------------------------------------------------------------
// Tagged pointer object table: entry memory
// One write port and one registered read port; a read at the address being
// written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
`default_nettype none

module tpot_entry_mem
  import tpot_pkg::*;
#(
  parameter int unsigned DEPTH = TABLE_ENTRIES_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data
);

  entry_t ent_mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= ent_mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/tpot_free_stack.sv @@
// ----------------------------------------------------------------------------
// Tagged pointer object table: free list
// Freed entries sit on a stack (top cached, next one prefetched each cycle);
// below it lie the never-used entries, tracked by a fill count.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tagged_pointer_object_table_core_defines.svh"

module tpot_free_stack
  import tpot_pkg::*;
#(
  parameter int unsigned DEPTH = TABLE_ENTRIES_DEF,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire stk_cmd_t      cmd,
  input  wire logic [AW-1:0] push_idx,
  output logic [AW-1:0]      head_idx,
  output logic               has_free,
  output logic [CW-1:0]      fresh_nxt
);

  localparam logic [CW-1:0] FILL_MAX = CW'(DEPTH);

  logic [CW-1:0] sp_r, sp_nxt;
  logic [CW-1:0] fresh_r;
  logic [AW-1:0] top_r, top_nxt;
  logic [AW-1:0] second_r;
  logic [AW-1:0] stk_mem [DEPTH];
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign has_free = (sp_r != '0) || (fresh_r != FILL_MAX);
  assign head_idx = (sp_r != '0) ? top_r : fresh_r[AW-1:0];

  always_comb begin
    sp_nxt    = sp_r;
    fresh_nxt = fresh_r;
    top_nxt   = top_r;
    wr_en     = 1'b0;
    wr_addr   = AW'(sp_r - CW'(1));
    if (cmd.pop) begin
      if (sp_r != '0) begin
        sp_nxt  = sp_r - CW'(1);
        top_nxt = second_r;
      end else begin
        fresh_nxt = fresh_r + CW'(1);
      end
    end else if (cmd.push) begin
      // old top drops into the memory
      wr_en   = (sp_r != '0);
      top_nxt = push_idx;
      sp_nxt  = sp_r + CW'(1);
    end
    // keep the entry below the top ready for a pop next cycle
    rd_addr = AW'(sp_nxt - CW'(2));
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stk_mem[wr_addr] <= top_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      second_r <= top_r;
    end else begin
      second_r <= stk_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r    <= '0;
      fresh_r <= '0;
    end else begin
      sp_r    <= sp_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
  end

  `TPOT_ASSERT_HOLDS(a_stack_le_fill, sp_r <= fresh_r, "free stack deeper than allocated entries")
  `TPOT_ASSERT_HOLDS(a_fill_in_range, fresh_r <= FILL_MAX, "fill count beyond table depth")
  `TPOT_ASSERT_IMP(a_pop_has_free, cmd.pop, has_free, "pop with no free entry")
  `TPOT_ASSERT_NXT(a_fresh_pop, cmd.pop && (sp_r == '0), fresh_r == $past(fresh_r) + CW'(1), "fill count did not advance")

endmodule

`default_nettype wire

@@ rtl/tagged_pointer_object_table_core.sv @@
// Stages: an accepted beat is registered as the held item, its result at the output.
// Throughput: one item per cycle while out_stall is low; the entry table read is
// issued at accept and registered, the free stack keeps top and next in registers.
// Reset: synchronous, active low; clears handshake state and the fill count and opens
// the size window. Table entries not yet allocated read as zero, so no clearing pass.
// ----------------------------------------------------------------------------
// Tagged pointer object table core
// Object table with free list; tags pointers with entry index plus one.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tagged_pointer_object_table_core_defines.svh"

module tagged_pointer_object_table_core
  import tpot_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_data
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [TAG_W:0] LAST_TAG = (TAG_W + 1)'(TABLE_ENTRIES);

  logic [ADDR_W-1:0] min_size_r, max_size_r;

  logic      s1_v_r;
  in_item_t  s1_item_r;
  logic      s1_ok_r;
  logic      out_v_r;
  out_item_t out_item_r;

  logic fire, in_acc;

  logic [TAG_W-1:0] in_tag, in_idx;

  entry_t        ent_rd, ent, ent_wd;
  logic          ent_we_raw, ent_we;
  logic [AW-1:0] ent_wa;
  stk_cmd_t      cmd_raw, cmd;
  logic [AW-1:0] head_idx;
  logic          has_free;
  logic [CW-1:0] fresh_nxt;

  logic [TAG_W-1:0]  tag, idx;
  logic [ADDR_W-1:0] plain, baddr, bsize;
  logic              has_tag, tag_valid, untracked;
  logic [ADDR_W:0]   bound_end;
  status_t           chk_status;
  out_item_t         res;

  // handshake
  assign fire      = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall  = s1_v_r && !fire;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_v_r;
  assign out_data  = out_item_r;

  assign in_tag = in_data.tagged_pointer[PTR_W-1:ADDR_W];
  assign in_idx = in_tag - TAG_W'(1);

  tpot_entry_mem #(
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_mem (
    .clk     (clk),
    .wr_en   (ent_we),
    .wr_addr (ent_wa),
    .wr_data (ent_wd),
    .rd_en   (in_acc),
    .rd_addr (in_idx[AW-1:0]),
    .rd_data (ent_rd)
  );

  tpot_free_stack #(
    .DEPTH (TABLE_ENTRIES)
  ) u_free_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .push_idx  (idx[AW-1:0]),
    .head_idx  (head_idx),
    .has_free  (has_free),
    .fresh_nxt (fresh_nxt)
  );

  // operation logic on the held item
  assign tag       = s1_item_r.tagged_pointer[PTR_W-1:ADDR_W];
  assign plain     = s1_item_r.tagged_pointer[ADDR_W-1:0];
  assign baddr     = s1_item_r.block_address;
  assign bsize     = s1_item_r.block_size;
  assign idx       = tag - TAG_W'(1);
  assign has_tag   = (tag != '0);
  assign tag_valid = has_tag && ({1'b0, tag} <= LAST_TAG);
  assign untracked = (bsize < min_size_r) || (bsize > max_size_r);
  // entries past the fill count were never written and are read as zero
  assign ent       = s1_ok_r ? ent_rd : '0;
  assign bound_end = {1'b0, ent.base} + {1'b0, ent.size};

  always_comb begin
    if (!has_tag) begin
      chk_status = ST_UNTAGGED;
    end else if (!tag_valid) begin
      chk_status = ST_BAD_TAG;
    end else if (!ent.in_use) begin
      chk_status = ST_NOT_IN_USE;
    end else begin
      chk_status = ST_OK;
    end
  end

  always_comb begin
    res               = '0;
    res.status        = ST_OK;
    cmd_raw           = '0;
    ent_we_raw        = 1'b0;
    ent_wa            = idx[AW-1:0];
    ent_wd.base       = baddr;
    ent_wd.size       = bsize;
    ent_wd.in_use     = 1'b1;
    case (s1_item_r.op)
      OP_ALLOC: begin
        res.result_pointer = {TAG_W'(0), baddr};
        if (untracked) begin
          res.status = ST_UNTRACKED;
        end else if (!has_free) begin
          res.status = ST_FULL;
        end else begin
          res.result_pointer = {TAG_W'(head_idx) + TAG_W'(1), baddr};
          ent_we_raw         = 1'b1;
          ent_wa             = head_idx;
          cmd_raw.pop        = 1'b1;
        end
      end
      OP_FREE: begin
        res.result_pointer = {TAG_W'(0), plain};
        res.status         = chk_status;
        if (chk_status == ST_OK) begin
          ent_we_raw    = 1'b1;
          ent_wd.base   = ent.base;
          ent_wd.size   = ent.size;
          ent_wd.in_use = 1'b0;
          cmd_raw.push  = 1'b1;
        end
      end
      OP_REALLOC: begin
        res.result_pointer = {TAG_W'(0), baddr};
        res.status         = chk_status;
        if (chk_status == ST_OK) begin
          res.result_pointer = {tag, baddr};
          res.base_mismatch  = (plain != ent.base);
          ent_we_raw         = 1'b1;
        end
      end
      OP_CHECK: begin
        res.result_pointer = {TAG_W'(0), plain};
        res.status         = chk_status;
        // bounds are reported even for an entry not in use
        if (tag_valid) begin
          res.in_bounds = (plain >= ent.base) && ({1'b0, plain} < bound_end);
        end
      end
      default: begin
      end
    endcase
  end

  assign ent_we   = ent_we_raw && fire;
  assign cmd.pop  = cmd_raw.pop && fire;
  assign cmd.push = cmd_raw.push && fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      min_size_r <= '0;
      max_size_r <= ADDR_MAX;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (fire) begin
        s1_v_r <= 1'b0;
      end
      if (fire) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_SIZE: min_size_r <= cfg_data;
          CFG_MAX_SIZE: max_size_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_data;
      s1_ok_r   <= (in_tag != '0) && ({1'b0, in_tag} <= (TAG_W + 1)'(fresh_nxt));
    end
    if (fire) begin
      out_item_r <= res;
    end
  end

  `TPOT_ASSERT_IMP(a_mismatch_ok, out_v_r && out_item_r.base_mismatch, out_item_r.status == ST_OK, "base mismatch on failed beat")
  `TPOT_ASSERT_IMP(a_bounds_valid_tag, out_v_r && out_item_r.in_bounds, (out_item_r.status == ST_OK) || (out_item_r.status == ST_NOT_IN_USE), "in bounds without a valid tag")
  `TPOT_ASSERT_NXT(a_full_reported, fire && (s1_item_r.op == OP_ALLOC) && !untracked && !has_free, out_item_r.status == ST_FULL, "alloc on empty list not reported full")

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged pointer object table testbench
// Drives alloc, free, realloc and check beats against a cycle-free model of
// the object table and its free list, and compares every result beat in order.
// Covers tag edge cases, size window extremes, a completely full table and a
// long output hold-off, with random gaps on both channels.
// ----------------------------------------------------------------------------

module testbench;
  import tpot_pkg::*;

  localparam int TBL_DEPTH    = TABLE_ENTRIES_DEF;
  localparam int LONG_HOLD    = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int RANDOM_ITEMS = 420;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MIN_SIZE;
  logic [ADDR_W-1:0]    cfg_data  = '0;

  tagged_pointer_object_table_core #(
    .TABLE_ENTRIES(TBL_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // table model state
  logic [ADDR_W-1:0] slot_base [TBL_DEPTH];
  logic [ADDR_W-1:0] slot_size [TBL_DEPTH];
  logic              slot_busy [TBL_DEPTH];
  int                link_next [TBL_DEPTH];
  logic              link_end  [TBL_DEPTH];
  int                free_head_idx;
  logic              free_empty;
  logic [ADDR_W-1:0] size_min;
  logic [ADDR_W-1:0] size_max;

  out_item_t pointer_results[$];
  int        live_slots[$];

  logic idle_off      = 1'b0;
  logic long_hold_req = 1'b0;
  int   error_count   = 0;
  int   sent_count    = 0;
  int   checked_count = 0;
  int   quiet_cycles  = 0;
  int   status_seen[8];

  function automatic void log_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endfunction

  function automatic logic [ADDR_W-1:0] rand48();
    logic [ADDR_W-1:0] v;
    case ($urandom_range(0, 15))
      0: v = '0;
      1: v = ADDR_MAX;
      default: begin
        v[31:0]        = $urandom();
        v[ADDR_W-1:32] = 16'($urandom_range(0, 16'hFFFF));
      end
    endcase
    return v;
  endfunction

  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one table operation: returns the result beat and updates the model
  function automatic out_item_t apply_table_op(input in_item_t it);
    out_item_t         r;
    logic [TAG_W-1:0]  tag;
    logic [ADDR_W-1:0] plain;
    logic              in_range;
    int                idx;
    int                h;
    tag   = it.tagged_pointer[PTR_W-1:ADDR_W];
    plain = it.tagged_pointer[ADDR_W-1:0];
    idx   = int'(tag) - 1;
    r     = '0;
    r.status = ST_OK;
    if (it.op == OP_ALLOC) begin
      r.result_pointer = {{TAG_W{1'b0}}, it.block_address};
      // window test wins over the full test
      if (it.block_size < size_min || it.block_size > size_max) begin
        r.status = ST_UNTRACKED;
      end else if (free_empty || free_head_idx >= TBL_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        h               = free_head_idx;
        free_empty      = link_end[h];
        free_head_idx   = link_next[h];
        slot_busy[h]    = 1'b1;
        slot_base[h]    = it.block_address;
        slot_size[h]    = it.block_size;
        r.result_pointer = {TAG_W'(h + 1), it.block_address};
      end
    end else begin
      if (it.op == OP_REALLOC) r.result_pointer = {{TAG_W{1'b0}}, it.block_address};
      else r.result_pointer = {{TAG_W{1'b0}}, plain};
      in_range = (tag != '0) && (idx < TBL_DEPTH);
      if (tag == '0) r.status = ST_UNTAGGED;
      else if (!in_range) r.status = ST_BAD_TAG;
      else if (!slot_busy[idx]) r.status = ST_NOT_IN_USE;
      if (it.op == OP_FREE && r.status == ST_OK) begin
        slot_busy[idx] = 1'b0;
        link_next[idx] = free_head_idx;
        link_end[idx]  = free_empty;
        free_head_idx  = idx;
        free_empty     = 1'b0;
      end else if (it.op == OP_REALLOC && r.status == ST_OK) begin
        r.base_mismatch  = (plain != slot_base[idx]);
        slot_base[idx]   = it.block_address;
        slot_size[idx]   = it.block_size;
        r.result_pointer = {TAG_W'(idx + 1), it.block_address};
      end else if (it.op == OP_CHECK && in_range) begin
        // bounds are 49 bits wide: base plus size may pass the top of memory
        r.in_bounds = (plain >= slot_base[idx]) &&
                      ({1'b0, plain} < {1'b0, slot_base[idx]} + {1'b0, slot_size[idx]});
      end
    end
    return r;
  endfunction

  function automatic in_item_t table_req(input op_t op, input logic [TAG_W-1:0] tag,
                                         input logic [ADDR_W-1:0] ptr_addr,
                                         input logic [ADDR_W-1:0] addr,
                                         input logic [ADDR_W-1:0] size);
    in_item_t it;
    it.op             = op;
    it.tagged_pointer = {tag, ptr_addr};
    it.block_address  = addr;
    it.block_size     = size;
    return it;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_block_size();
    case ($urandom_range(0, 9))
      0: return size_min;
      1: return size_max;
      2: return size_min - 1'b1;
      3: return size_max + 1'b1;
      4: return rand48();
      default: return size_min + ADDR_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] probe_address(input int slot);
    case ($urandom_range(0, 5))
      0: return slot_base[slot];
      1: return slot_base[slot] + slot_size[slot] - 1'b1;
      2: return slot_base[slot] + slot_size[slot];
      3: return slot_base[slot] - 1'b1;
      4: return slot_base[slot] + (rand48() & slot_size[slot]);
      default: return rand48();
    endcase
  endfunction

  function automatic in_item_t random_table_op(input op_t op);
    in_item_t          it;
    logic [TAG_W-1:0]  tag;
    logic [ADDR_W-1:0] addr;
    int                slot;
    it.op             = op;
    it.tagged_pointer = {$urandom(), $urandom()};
    it.block_address  = rand48();
    it.block_size     = (op == OP_ALLOC || op == OP_REALLOC) ? pick_block_size() : rand48();
    if (op != OP_ALLOC) begin
      slot = -1;
      case ($urandom_range(0, 9))
        0: tag = '0;
        1: tag = ($urandom_range(0, 3) == 0) ? TAG_W'(TBL_DEPTH + 1) :
                 TAG_W'($urandom_range(TBL_DEPTH + 1, 16'hFFFF));
        2: begin
          slot = $urandom_range(0, TBL_DEPTH - 1);
          tag  = TAG_W'(slot + 1);
        end
        default: begin
          if (live_slots.size() > 0) slot = live_slots[$urandom_range(0, live_slots.size() - 1)];
          else slot = $urandom_range(0, TBL_DEPTH - 1);
          tag = TAG_W'(slot + 1);
        end
      endcase
      addr = (slot >= 0) ? probe_address(slot) : rand48();
      if (op == OP_REALLOC && slot >= 0 && $urandom_range(0, 1) == 1) addr = slot_base[slot];
      it.tagged_pointer = {tag, addr};
    end
    return it;
  endfunction

  // offer one beat and wait for it to be taken; entered and left at a clock edge
  task automatic issue_request(input in_item_t item);
    int        idle;
    int        slot;
    int        hits[$];
    out_item_t want;
    idle = (idle_off || $urandom_range(0, 1) == 1) ? 0 : idle_span();
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    want = apply_table_op(item);
    pointer_results.push_back(want);
    sent_count++;
    slot = int'(item.tagged_pointer[PTR_W-1:ADDR_W]) - 1;
    if (item.op == OP_ALLOC && want.status == ST_OK)
      live_slots.push_back(int'(want.result_pointer[PTR_W-1:ADDR_W]) - 1);
    if (item.op == OP_FREE && want.status == ST_OK) begin
      hits = live_slots.find_first_index(x) with (x == slot);
      if (hits.size() > 0) live_slots.delete(hits[0]);
    end
  endtask

  task automatic settle_table();
    in_valid <= 1'b0;
    while (pointer_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_size_window(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_SIZE;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= CFG_MAX_SIZE;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_we   <= 1'b0;
    size_min = lo;
    size_max = hi;
    @(posedge clk);
  endtask

  task automatic test_directed_cases();
    // untouched entries, tag zero, tags past the table
    issue_request(table_req(OP_CHECK, 16'd1, '0, rand48(), rand48()));
    issue_request(table_req(OP_CHECK, '0, rand48(), rand48(), rand48()));
    issue_request(table_req(OP_FREE, '0, rand48(), rand48(), rand48()));
    issue_request(table_req(OP_REALLOC, '0, rand48(), 48'h7000, 48'h40));
    issue_request(table_req(OP_FREE, TAG_W'(TBL_DEPTH + 1), rand48(), rand48(), rand48()));
    issue_request(table_req(OP_CHECK, 16'hFFFF, ADDR_MAX, rand48(), rand48()));
    issue_request(table_req(OP_REALLOC, TAG_W'(TBL_DEPTH + 1), '0, 48'h7000, 48'h40));
    issue_request(table_req(OP_FREE, 16'd1, '0, rand48(), rand48()));
    issue_request(table_req(OP_REALLOC, 16'd1, '0, 48'h7000, 48'h40));
    // allocs at both extremes of address and size
    issue_request(table_req(OP_ALLOC, '0, '0, '0, '0));
    issue_request(table_req(OP_ALLOC, '0, '0, ADDR_MAX, ADDR_MAX));
    issue_request(table_req(OP_CHECK, 16'd2, ADDR_MAX, rand48(), rand48()));
    issue_request(table_req(OP_CHECK, 16'd1, '0, rand48(), rand48()));
    // realloc with matching and stale old base
    issue_request(table_req(OP_REALLOC, 16'd1, '0, 48'h1000, 48'h100));
    issue_request(table_req(OP_REALLOC, 16'd1, 48'h2000, 48'h1000, 48'h100));
    issue_request(table_req(OP_CHECK, 16'd1, 48'h1000, rand48(), rand48()));
    issue_request(table_req(OP_CHECK, 16'd1, 48'h10FF, rand48(), rand48()));
    issue_request(table_req(OP_CHECK, 16'd1, 48'h1100, rand48(), rand48()));
    issue_request(table_req(OP_CHECK, 16'd1, 48'h0FFF, rand48(), rand48()));
    // double free, then bounds still come from the old entry
    issue_request(table_req(OP_FREE, 16'd1, 48'h1000, rand48(), rand48()));
    issue_request(table_req(OP_FREE, 16'd1, 48'h1000, rand48(), rand48()));
    issue_request(table_req(OP_CHECK, 16'd1, 48'h1000, rand48(), rand48()));
    issue_request(table_req(OP_ALLOC, '0, '0, 48'h5000, 48'h10));
    issue_request(table_req(OP_FREE, 16'd2, ADDR_MAX, rand48(), rand48()));
    issue_request(table_req(OP_CHECK, TAG_W'(TBL_DEPTH), rand48(), rand48(), rand48()));
    settle_table();
  endtask

  task automatic test_size_windows();
    logic [ADDR_W-1:0] lows  [5];
    logic [ADDR_W-1:0] highs [5];
    int                w;
    int                n;
    lows  = '{48'd0, ADDR_MAX, 48'd100, 48'd1000, 48'd0};
    highs = '{48'd0, ADDR_MAX, 48'd50, 48'd4000, ADDR_MAX};
    for (w = 0; w < 5; w++) begin
      set_size_window(lows[w], highs[w]);
      for (n = 0; n < 14; n++) begin
        if ($urandom_range(0, 9) < 6) issue_request(random_table_op(OP_ALLOC));
        else issue_request(random_table_op(OP_FREE));
      end
      settle_table();
    end
  endtask

  task automatic test_table_fill();
    int n;
    n = 0;
    // back-to-back beats into a long output hold-off
    idle_off      = 1'b1;
    long_hold_req = 1'b1;
    while (!free_empty) begin
      if ($urandom_range(0, 9) == 0) issue_request(random_table_op(OP_CHECK));
      else issue_request(random_table_op(OP_ALLOC));
      n++;
      if (n == 80) idle_off = 1'b0;
    end
    idle_off = 1'b0;
    repeat (6) issue_request(random_table_op(OP_ALLOC));
    settle_table();
    // untracked size reported ahead of a full table
    set_size_window(48'd16, 48'd64);
    issue_request(table_req(OP_ALLOC, '0, '0, rand48(), 48'd8));
    issue_request(table_req(OP_ALLOC, '0, '0, rand48(), 48'd32));
    issue_request(table_req(OP_ALLOC, '0, '0, rand48(), 48'd64));
    issue_request(table_req(OP_ALLOC, '0, '0, rand48(), 48'd65));
    settle_table();
    set_size_window('0, ADDR_MAX);
  endtask

  task automatic test_random_mix();
    int   n;
    int   r;
    op_t  op;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) idle_off = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 30) op = OP_ALLOC;
      else if (r < 55) op = OP_FREE;
      else if (r < 70) op = OP_REALLOC;
      else op = OP_CHECK;
      issue_request(random_table_op(op));
    end
    idle_off = 1'b0;
    settle_table();
  endtask

  // receiver: random stalls, quiet stretches, and one long hold on request
  initial begin : result_stall_gen
    int span;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        span = LONG_HOLD;
      end else if (idle_off) begin
        out_stall <= 1'b0;
        span = 1;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        span = idle_span();
      end
      repeat (span - 1) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      checked_count++;
      status_seen[out_data.status]++;
      if (pointer_results.size() == 0) begin
        log_error($sformatf("unexpected result beat: ptr %h status %0d",
                            out_data.result_pointer, out_data.status));
      end else begin
        want = pointer_results.pop_front();
        if (out_data.result_pointer !== want.result_pointer ||
            out_data.status !== want.status ||
            out_data.in_bounds !== want.in_bounds ||
            out_data.base_mismatch !== want.base_mismatch)
          log_error($sformatf({"result %0d: expected ptr %h st %0d inb %b mism %b,",
                               " got ptr %h st %0d inb %b mism %b"}, checked_count,
                              want.result_pointer, want.status, want.in_bounds,
                              want.base_mismatch, out_data.result_pointer,
                              out_data.status, out_data.in_bounds, out_data.base_mismatch));
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : main_seq
    int i;
    for (i = 0; i < TBL_DEPTH; i++) begin
      slot_base[i] = '0;
      slot_size[i] = '0;
      slot_busy[i] = 1'b0;
      link_next[i] = i + 1;
      link_end[i]  = (i == TBL_DEPTH - 1);
    end
    free_head_idx = 0;
    free_empty    = 1'b0;
    size_min      = '0;
    size_max      = ADDR_MAX;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_size_windows();
    test_table_fill();
    test_random_mix();

    repeat (4) @(posedge clk);
    if (pointer_results.size() != 0)
      log_error($sformatf("%0d expected results never arrived", pointer_results.size()));
    $display("covered %0d requests, %0d results checked, %0d mismatches; five size windows,",
             sent_count, checked_count, error_count);
    $display("  a full table, statuses ok %0d untagged %0d bad tag %0d idle %0d full %0d untracked %0d",
             status_seen[ST_OK], status_seen[ST_UNTAGGED], status_seen[ST_BAD_TAG],
             status_seen[ST_NOT_IN_USE], status_seen[ST_FULL], status_seen[ST_UNTRACKED]);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/tpot_pkg.sv
rtl/tpot_entry_mem.sv
rtl/tpot_free_stack.sv
rtl/tagged_pointer_object_table_core.sv
tb/testbench.sv
